// ===== design/esc_pkg.sv =====
// shared constants and helper functions for the epoch seconds to calendar converter
// no dependencies; imported by epoch_seconds_to_calendar
package esc_pkg;

  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;

  // quotient bits needed by each long division step
  localparam int unsigned DayQBits  = 16;
  localparam int unsigned HourQBits = 5;
  localparam int unsigned MinQBits  = 6;

  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [11:0] CenturyNoLeap = 12'd2100;
  localparam logic [11:0] LastYear     = 12'd2106;
  localparam logic [8:0]  YearLenShort = 9'd365;
  localparam logic [8:0]  YearLenLong  = 9'd366;
  localparam logic [2:0]  EpochWdOff   = 3'd3;    // thursday, counted from monday as 0
  localparam logic [3:0]  LastMonthIdx = 4'd11;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 48;

  // gregorian rule narrowed to 1970..2106: 2000 leaps, 2100 does not
  function automatic logic is_leap(input logic [11:0] yr);
    is_leap = (yr[1:0] == 2'd0) && (yr != CenturyNoLeap);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    month_len = len;
  endfunction

  // weekday offset plus a small step, wrapped into 0..6
  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [1:0] inc);
    logic [3:0] s;
    s = {1'b0, wd} + {2'b00, inc};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    wd_add = s[2:0];
  endfunction

  // remainder by seven of a value below 63
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    mod7 = r[2:0];
  endfunction

endpackage

// ===== design/epoch_seconds_to_calendar.sv =====
// epoch seconds to calendar date and time converter, top level
// depends on esc_pkg for constants, month lengths and weekday helpers
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second, minute, hour,
// weekday (monday = 1), full year, month and day of month. The divisions and the year and
// month walks run through one 32-bit compare-and-subtract unit under a small sequencer:
// long division by 86400, 3600 and 60 for 16, 5 and 6 quotient bits, then a walk over the
// years from 1970 (up to 136) and over the months (up to 12), between an accept state and
// a deliver state. Delivery waits while the previous result is still unaccepted;
// s_axis_tready is high only while no conversion is in flight. The result sits in an
// output register, so a new word is taken while the previous result waits for
// m_axis_tready.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                      // [19:17] weekday, [31:20] full_year, [35:32] month,
                                      // [40:36] day_of_month, [47:41] zero
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  state_t      state;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [3:0]  cnt;
  logic [15:0] q;
  logic [5:0]  qs;
  logic [11:0] year;
  logic [2:0]  wd;
  logic [5:0]  second_r;
  logic [5:0]  minute_r;
  logic [4:0]  hour_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;

  logic [31:0] subtrahend;
  logic [32:0] diff;
  logic        ge;
  logic        leap;
  logic [4:0]  mlen;
  logic [31:0] dvs_day;
  logic [31:0] dvs_hour;
  logic [31:0] dvs_min;

  assign dvs_day  = 32'(SecPerDay  << (DayQBits  - 1));
  assign dvs_hour = 32'(SecPerHour << (HourQBits - 1));
  assign dvs_min  = 32'(SecPerMin  << (MinQBits  - 1));

  assign leap = is_leap(year);
  assign mlen = month_len(leap, cnt);

  // the one shared compare and subtract unit
  always_comb begin
    unique case (state)
      ST_DIV_DAY, ST_DIV_HOUR, ST_DIV_MIN: subtrahend = dvs;
      ST_YEAR:  subtrahend = {23'd0, (leap ? YearLenLong : YearLenShort)};
      ST_MONTH: subtrahend = {27'd0, mlen};
      default:  subtrahend = '0;
    endcase
    diff = {1'b0, rem} - {1'b0, subtrahend};
    ge   = ~diff[32];
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            rem   <= s_axis_tdata;
            dvs   <= dvs_day;
            cnt   <= 4'(DayQBits - 1);
            q     <= '0;
            state <= ST_DIV_DAY;
          end
        end
        ST_DIV_DAY: begin
          if (ge) begin
            rem <= diff[31:0];
          end
          q <= {q[14:0], ge};
          if (cnt == 4'd0) begin
            dvs   <= dvs_hour;
            cnt   <= 4'(HourQBits - 1);
            qs    <= '0;
            state <= ST_DIV_HOUR;
          end else begin
            dvs <= dvs >> 1;
            cnt <= cnt - 4'd1;
          end
        end
        ST_DIV_HOUR: begin
          if (ge) begin
            rem <= diff[31:0];
          end
          if (cnt == 4'd0) begin
            hour_r <= {qs[3:0], ge};
            dvs    <= dvs_min;
            cnt    <= 4'(MinQBits - 1);
            qs     <= '0;
            state  <= ST_DIV_MIN;
          end else begin
            qs  <= {qs[4:0], ge};
            dvs <= dvs >> 1;
            cnt <= cnt - 4'd1;
          end
        end
        ST_DIV_MIN: begin
          if (cnt == 4'd0) begin
            minute_r <= {qs[4:0], ge};
            second_r <= ge ? diff[5:0] : rem[5:0];
            // day count moves into the remainder for the year walk
            rem      <= {16'd0, q};
            year     <= EpochYear;
            wd       <= EpochWdOff;
            state    <= ST_YEAR;
          end else begin
            if (ge) begin
              rem <= diff[31:0];
            end
            qs  <= {qs[4:0], ge};
            dvs <= dvs >> 1;
            cnt <= cnt - 4'd1;
          end
        end
        ST_YEAR: begin
          if (ge) begin
            rem  <= diff[31:0];
            year <= year + 12'd1;
            wd   <= wd_add(wd, leap ? 2'd2 : 2'd1);
          end else begin
            cnt   <= '0;
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (ge && (cnt != LastMonthIdx)) begin
            rem <= diff[31:0];
            cnt <= cnt + 4'd1;
            wd  <= wd_add(wd, 2'(mlen - 5'd28));
          end else begin
            // whatever is left lies inside this month
            month_r <= cnt + 4'd1;
            day_r   <= rem[4:0] + 5'd1;
            wd      <= mod7({3'd0, wd} + {1'b0, rem[4:0]});
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {7'd0, day_r, month_r, year, wd + 3'd1, hour_r, minute_r,
                              second_r};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_division: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_DIV_DAY))
    else $error("accepted word did not start the day division");

  a_month_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (cnt <= LastMonthIdx))
    else $error("month index ran past december");

  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (year >= EpochYear && year <= LastYear))
    else $error("year walk left the representable range");

  a_out_weekday: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:17] != 3'd0))
    else $error("weekday out of range");

  a_out_month_day: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[35:32] != 4'd0 && m_axis_tdata[35:32] <= 4'd12 &&
                       m_axis_tdata[40:36] != 5'd0))
    else $error("month or day of month out of range");
`endif

endmodule
